// File: sv/svv_pkg.sv
package svv_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Width of the velocity increment dividend (dtf * |force|) and of the mass divisor.
    localparam int NUM_W = 62;
    localparam int DEN_W = 31;

    // The velocity increment is clamped to plus or minus this power of two.
    localparam int DV_LIMIT_BIT = 40;

    typedef enum logic [1:0] {
        CMD_FIRST = 2'd0,
        CMD_FINAL = 2'd1,
        CMD_COPY  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_GROUP = 2'd0,
        REG_DT    = 2'd1,
        REG_DTF   = 2'd2,
        REG_NONE  = 2'd3
    } t_reg;

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } t_sat;

    // Per-item context that rides alongside the divider.
    typedef struct packed {
        t_cmd               cmd;
        logic               grp;
        logic [1:0]         axis;
        logic signed [31:0] x;
        logic signed [31:0] v;
        logic signed [31:0] e;
        logic signed [31:0] ne;
        logic               sat_e;
        logic               fneg;
    } t_ctx;

    // Clips a wide signed sum to the signed 32-bit range.
    function automatic t_sat sat32(input logic signed [65:0] a);
        t_sat r;
        if (a > 66'sh0_7FFF_FFFF) begin
            r.val  = 32'h7FFF_FFFF;
            r.clip = 1'b1;
        end else if (a < -66'sh0_8000_0000) begin
            r.val  = 32'h8000_0000;
            r.clip = 1'b1;
        end else begin
            r.val  = a[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: sv/svv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module svv_div
    import svv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_vld,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [0:NUM_W];
    logic [NUM_W-1:0] r_num [0:NUM_W];
    logic [NUM_W-1:0] r_quo [0:NUM_W];
    logic [DEN_W-1:0] r_den [0:NUM_W];
    logic             r_vld [0:NUM_W];

    logic [DEN_W-1:0] n_rem [1:NUM_W];
    logic [NUM_W-1:0] n_num [1:NUM_W];
    logic [NUM_W-1:0] n_quo [1:NUM_W];
    logic [DEN_W:0]   tr    [0:NUM_W-1];
    logic [DEN_W:0]   diff  [0:NUM_W-1];
    logic             ge    [0:NUM_W-1];

    always_comb begin
        for (int s = 0; s < NUM_W; s++) begin
            tr[s]      = {r_rem[s], r_num[s][NUM_W-1]};
            diff[s]    = tr[s] - {1'b0, r_den[s]};
            ge[s]      = (tr[s] >= {1'b0, r_den[s]});
            n_rem[s+1] = ge[s] ? diff[s][DEN_W-1:0] : tr[s][DEN_W-1:0];
            n_num[s+1] = {r_num[s][NUM_W-2:0], 1'b0};
            n_quo[s+1] = {r_quo[s][NUM_W-2:0], ge[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_num[0] <= i_num;
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        for (int s = 1; s <= NUM_W; s++) begin
            r_rem[s] <= n_rem[s];
            r_num[s] <= n_num[s];
            r_quo[s] <= n_quo[s];
            r_den[s] <= r_den[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NUM_W; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s <= NUM_W; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_vld = r_vld[NUM_W];
    assign o_quo = r_quo[NUM_W];

endmodule

// File: sv/sph_velocity_verlet_step.sv
// Velocity-Verlet update for one axis of one SPH particle per transaction, signed
// fixed point with FRAC_BITS fraction bits. A transaction is taken whenever start
// is high; busy never rises, because the pipeline never stalls. Every transaction
// yields exactly one result, shown for one cycle with o_done, after passing stage 1,
// stage 2, the divider that forms dtf*force/mass (one input register and 62
// bit-per-stage steps), stage 3, stage 4 and the output register. One transaction
// may enter every cycle. The receiver cannot hold results off and needs none:
// results leave in order at the input rate.
// Configuration writes are always ready but must only be issued while no
// transaction is in flight.
module sph_velocity_verlet_step
    import svv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_particle_mask,
    input  logic [30:0]        i_mass,
    input  logic [1:0]         i_axis,
    input  logic signed [31:0] i_position,
    input  logic signed [31:0] i_velocity,
    input  logic signed [31:0] i_force_req,
    input  logic signed [31:0] i_energy,
    input  logic signed [31:0] i_energy_rate,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [31:0] o_new_position,
    output logic signed [31:0] o_new_velocity,
    output logic signed [31:0] o_velocity_estimate,
    output logic signed [31:0] o_new_energy,
    output logic               o_estimate_written,
    output logic               o_in_group,
    output logic               o_saturated
);

    localparam int LATENCY = NUM_W + 6;

    // Configuration registers.
    logic [31:0] r_group;
    logic [30:0] r_dt;
    logic [30:0] r_dtf;

    // The configuration port never pushes back.
    assign o_cfg_ready = 1'b1;
    // The pipeline advances every cycle, so the command side is never held off.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= 32'd1;
            r_dt    <= 31'd65;
            r_dtf   <= 31'd32;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_GROUP: r_group <= i_cfg_data;
                REG_DT:    r_dt    <= i_cfg_data[30:0];
                REG_DTF:   r_dtf   <= i_cfg_data[30:0];
                default:   ;
            endcase
        end
    end

    // Stage 1: capture the transaction and resolve group membership.
    logic               r_s1_vld;
    t_cmd               r_s1_cmd;
    logic               r_s1_grp;
    logic [1:0]         r_s1_axis;
    logic [30:0]        r_s1_mass;
    logic signed [31:0] r_s1_x;
    logic signed [31:0] r_s1_v;
    logic signed [31:0] r_s1_f;
    logic signed [31:0] r_s1_e;
    logic signed [31:0] r_s1_de;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd  <= t_cmd'(i_command);
        r_s1_grp  <= (i_particle_mask & r_group) != 32'd0;
        r_s1_axis <= i_axis;
        r_s1_mass <= i_mass;
        r_s1_x    <= i_position;
        r_s1_v    <= i_velocity;
        r_s1_f    <= i_force_req;
        r_s1_e    <= i_energy;
        r_s1_de   <= i_energy_rate;
    end

    // Stage 1 to 2: the two dtf products on magnitudes.
    logic [31:0] s1_fabs;
    logic [31:0] s1_deabs;
    logic [62:0] s1_fprod;
    logic [62:0] s1_eprod;

    always_comb begin
        s1_fabs  = r_s1_f[31]  ? (~r_s1_f  + 32'd1) : r_s1_f;
        s1_deabs = r_s1_de[31] ? (~r_s1_de + 32'd1) : r_s1_de;
        s1_fprod = 63'(r_dtf) * 63'(s1_fabs);
        s1_eprod = 63'(r_dtf) * 63'(s1_deabs);
    end

    logic               r_s2_vld;
    t_cmd               r_s2_cmd;
    logic               r_s2_grp;
    logic [1:0]         r_s2_axis;
    logic signed [31:0] r_s2_x;
    logic signed [31:0] r_s2_v;
    logic signed [31:0] r_s2_e;
    logic               r_s2_fneg;
    logic               r_s2_deneg;
    logic [NUM_W-1:0]   r_s2_num;
    logic [DEN_W-1:0]   r_s2_den;
    logic [62:0]        r_s2_eprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_cmd   <= r_s1_cmd;
        r_s2_grp   <= r_s1_grp;
        r_s2_axis  <= r_s1_axis;
        r_s2_x     <= r_s1_x;
        r_s2_v     <= r_s1_v;
        r_s2_e     <= r_s1_e;
        r_s2_fneg  <= r_s1_f[31];
        r_s2_deneg <= r_s1_de[31];
        r_s2_num   <= s1_fprod[NUM_W-1:0];
        // A zero mass divides by one.
        r_s2_den   <= (r_s1_mass == 31'd0) ? 31'd1 : r_s1_mass;
        r_s2_eprod <= s1_eprod;
    end

    // Stage 2: the energy sum is finished here and travels with the context.
    logic [62:0]        s2_emag;
    logic signed [65:0] s2_esum;
    t_sat               s2_esat;
    t_ctx               s2_ctx;

    always_comb begin
        s2_emag = r_s2_eprod >> FRAC_BITS;
        s2_esum = {{34{r_s2_e[31]}}, r_s2_e}
                  + (r_s2_deneg ? -{3'b0, s2_emag} : {3'b0, s2_emag});
        s2_esat = sat32(s2_esum);
        s2_ctx.cmd   = r_s2_cmd;
        s2_ctx.grp   = r_s2_grp;
        s2_ctx.axis  = r_s2_axis;
        s2_ctx.x     = r_s2_x;
        s2_ctx.v     = r_s2_v;
        s2_ctx.e     = r_s2_e;
        s2_ctx.ne    = s2_esat.val;
        s2_ctx.sat_e = s2_esat.clip;
        s2_ctx.fneg  = r_s2_fneg;
    end

    // Divider and its matching context delay line.
    logic             div_vld;
    logic [NUM_W-1:0] div_quo;
    t_ctx             r_dly [0:NUM_W];

    svv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .i_num   (r_s2_num),
        .i_den   (r_s2_den),
        .o_vld   (div_vld),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        r_dly[0] <= s2_ctx;
        for (int k = 1; k <= NUM_W; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // Stage 3: clamp the increment, form v+dv and v+2dv.
    localparam logic [NUM_W-1:0] DV_LIMIT = NUM_W'(1) << DV_LIMIT_BIT;

    logic [DV_LIMIT_BIT:0] s3_qc;
    logic signed [65:0]    s3_dv;
    logic signed [65:0]    s3_vw;
    t_sat                  s3_nv;
    t_sat                  s3_est;

    always_comb begin
        s3_qc  = (div_quo > DV_LIMIT) ? DV_LIMIT[DV_LIMIT_BIT:0] : div_quo[DV_LIMIT_BIT:0];
        s3_dv  = r_dly[NUM_W].fneg ? -{25'b0, s3_qc} : {25'b0, s3_qc};
        s3_vw  = {{34{r_dly[NUM_W].v[31]}}, r_dly[NUM_W].v};
        s3_nv  = sat32(s3_vw + s3_dv);
        s3_est = sat32(s3_vw + (s3_dv <<< 1));
    end

    logic               r_s3_vld;
    t_ctx               r_s3_ctx;
    logic signed [31:0] r_s3_nv;
    logic               r_s3_sat_v;
    logic signed [31:0] r_s3_est;
    logic               r_s3_sat_est;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_ctx     <= r_dly[NUM_W];
        r_s3_nv      <= s3_nv.val;
        r_s3_sat_v   <= s3_nv.clip;
        r_s3_est     <= s3_est.val;
        r_s3_sat_est <= s3_est.clip;
    end

    // Stage 4: dt times the new velocity magnitude.
    logic [31:0] s4_nvabs;
    logic [62:0] s4_prod;

    always_comb begin
        s4_nvabs = r_s3_nv[31] ? (~r_s3_nv + 32'd1) : r_s3_nv;
        s4_prod  = 63'(r_dt) * 63'(s4_nvabs);
    end

    logic               r_s4_vld;
    t_ctx               r_s4_ctx;
    logic signed [31:0] r_s4_nv;
    logic               r_s4_sat_v;
    logic signed [31:0] r_s4_est;
    logic               r_s4_sat_est;
    logic [62:0]        r_s4_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_ctx     <= r_s3_ctx;
        r_s4_nv      <= r_s3_nv;
        r_s4_sat_v   <= r_s3_sat_v;
        r_s4_est     <= r_s3_est;
        r_s4_sat_est <= r_s3_sat_est;
        r_s4_prod    <= s4_prod;
    end

    // Stage 5: position sum and the final selection by command, membership and axis.
    logic [62:0]        s5_sh;
    logic signed [65:0] s5_xsum;
    t_sat               s5_nx;
    logic               s5_act;
    logic               s5_first;
    logic               s5_ax0;
    logic signed [31:0] n_pos;
    logic signed [31:0] n_vel;
    logic signed [31:0] n_est;
    logic signed [31:0] n_eng;
    logic               n_estw;
    logic               n_sat;

    always_comb begin
        s5_sh    = r_s4_prod >> FRAC_BITS;
        s5_xsum  = {{34{r_s4_ctx.x[31]}}, r_s4_ctx.x}
                   + (r_s4_nv[31] ? -{3'b0, s5_sh} : {3'b0, s5_sh});
        s5_nx    = sat32(s5_xsum);
        s5_act   = r_s4_ctx.grp && (r_s4_ctx.cmd == CMD_FIRST || r_s4_ctx.cmd == CMD_FINAL);
        s5_first = r_s4_ctx.cmd == CMD_FIRST;
        s5_ax0   = r_s4_ctx.axis == 2'd0;

        n_pos  = (s5_act && s5_first) ? s5_nx.val : r_s4_ctx.x;
        n_vel  = s5_act ? r_s4_nv : r_s4_ctx.v;
        n_eng  = (s5_act && s5_ax0) ? r_s4_ctx.ne : r_s4_ctx.e;
        n_estw = r_s4_ctx.grp && (r_s4_ctx.cmd == CMD_FIRST || r_s4_ctx.cmd == CMD_COPY);
        if (s5_act && s5_first) begin
            n_est = r_s4_est;
        end else if (r_s4_ctx.grp && r_s4_ctx.cmd == CMD_COPY) begin
            n_est = r_s4_ctx.v;
        end else begin
            n_est = '0;
        end
        n_sat = s5_act && (r_s4_sat_v
                           || (s5_first && (r_s4_sat_est || s5_nx.clip))
                           || (s5_ax0 && r_s4_ctx.sat_e));
    end

    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s4_vld;
        end
    end

    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_est;
    logic signed [31:0] r_eng;
    logic               r_estw;
    logic               r_grp;
    logic               r_sat;

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_vel  <= n_vel;
        r_est  <= n_est;
        r_eng  <= n_eng;
        r_estw <= n_estw;
        r_grp  <= r_s4_ctx.grp;
        r_sat  <= n_sat;
    end

    assign o_done              = r_done;
    assign o_new_position      = r_pos;
    assign o_new_velocity      = r_vel;
    assign o_velocity_estimate = r_est;
    assign o_new_energy        = r_eng;
    assign o_estimate_written  = r_estw;
    assign o_in_group          = r_grp;
    assign o_saturated         = r_sat;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(LATENCY) o_done)
        else $error("transaction did not complete at the expected latency");

    a_out_group_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_in_group) |-> (!o_estimate_written && o_velocity_estimate == 32'd0))
        else $error("estimate produced for a particle outside the group");

    a_out_group_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_in_group) |-> !o_saturated)
        else $error("saturation reported for a pass-through particle");

    a_no_est_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_estimate_written) |-> (o_velocity_estimate == 32'd0))
        else $error("unwritten estimate is not zero");
`endif

endmodule
